@@ rtl/hit_grid_binning_sorter_defines.svh @@
// Assertion macros used by the checker file.
`ifndef HIT_GRID_BINNING_SORTER_DEFINES_SVH
`define HIT_GRID_BINNING_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define HGBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define HGBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hgbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hgbs_pkg;

    localparam int MAX_ENTRIES = 8192;
    localparam int MAX_BINS    = 8192;
    localparam int ENT_AW      = $clog2(MAX_ENTRIES);
    localparam int BIN_AW      = $clog2(MAX_BINS);
    localparam int CNT_W       = ENT_AW + 1;

    // request kinds
    localparam logic [2:0] KIND_INSERT    = 3'd0;
    localparam logic [2:0] KIND_FINALIZE  = 3'd1;
    localparam logic [2:0] KIND_READ_BIN  = 3'd2;
    localparam logic [2:0] KIND_READ_SLOT = 3'd3;
    localparam logic [2:0] KIND_CLEAR     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NFIN  = 2'd3;

    // result formats
    localparam logic [1:0] RES_PLAIN = 2'd0;
    localparam logic [1:0] RES_INS   = 2'd1;
    localparam logic [1:0] RES_BIN   = 2'd2;
    localparam logic [1:0] RES_SLOT  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_LAYER      = 3'd0;
    localparam logic [2:0] REG_PHI_COLS   = 3'd1;
    localparam logic [2:0] REG_T_ROWS     = 3'd2;
    localparam logic [2:0] REG_T_MIN      = 3'd3;
    localparam logic [2:0] REG_T_SCALE    = 3'd4;
    localparam logic [2:0] REG_PHI_SCALE  = 3'd5;
    localparam logic [2:0] REG_PHI_EDGE   = 3'd6;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_INS_MUL  = 5'd2;
    localparam logic [4:0] OP_INS_ROW  = 5'd3;
    localparam logic [4:0] OP_INS_WR0  = 5'd4;
    localparam logic [4:0] OP_INS_WR1  = 5'd5;
    localparam logic [4:0] OP_ZERO     = 5'd6;
    localparam logic [4:0] OP_IDX_RST  = 5'd7;
    localparam logic [4:0] OP_IDX_NEXT = 5'd8;
    localparam logic [4:0] OP_CNT_LOOK = 5'd9;
    localparam logic [4:0] OP_CNT_INC  = 5'd10;
    localparam logic [4:0] OP_PRE_RD   = 5'd11;
    localparam logic [4:0] OP_PRE_WR   = 5'd12;
    localparam logic [4:0] OP_SCT_LOOK = 5'd13;
    localparam logic [4:0] OP_SCT_WR   = 5'd14;
    localparam logic [4:0] OP_FIN_DONE = 5'd15;
    localparam logic [4:0] OP_RD_ISSUE = 5'd16;
    localparam logic [4:0] OP_CLEAR    = 5'd17;

    typedef struct packed {
        logic [5:0]        layer_select;
        logic [6:0]        phi_columns;
        logic [5:0]        t_rows;
        logic signed [15:0] t_min;
        logic [15:0]       t_scale;
        logic [15:0]       phi_scale;
        logic [16:0]       phi_edge_width;
    } t_cfg;

    typedef struct packed {
        logic [4:0] op;
        logic       emit;
        logic [1:0] res;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic range_err;
        logic full;
        logic need2;
        logic ready;
        logic idx_at_nb;
        logic idx_at_total;
        logic bin_ok;
        logic addr_bin_oob;
        logic addr_slot_oob;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/hit_grid_binning_sorter.sv @@
// Insert stores one entry, or two when an edge clone is stored.
// Finalize runs the count/scatter read-modify-write loops.
// One request at a time; busy is high until the result strobe cycle begins.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset clears control, configuration and counter registers; memories are not swept,
// as bin tables are only read after a finalize has rewritten them.
`timescale 1ns / 1ps
`default_nettype none
module hit_grid_binning_sorter import hgbs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_kind,
    input  wire logic [19:0]        i_hit_id,
    input  wire logic [5:0]         i_hit_layer,
    input  wire logic               i_hit_used,
    input  wire logic signed [15:0] i_phi,
    input  wire logic signed [15:0] i_t_coord,
    input  wire logic [12:0]        i_address,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [1:0]              o_accepted,
    output logic [13:0]             o_bin_first,
    output logic [13:0]             o_bin_count,
    output logic [19:0]             o_slot_hit_id,
    output logic signed [17:0]      o_slot_search_phi,
    output logic                    o_slot_is_clone,
    output logic [13:0]             o_total_stored,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layer_select   <= 6'd0;
            r_cfg.phi_columns    <= 7'd16;
            r_cfg.t_rows         <= 6'd16;
            r_cfg.t_min          <= 16'sh8000;
            r_cfg.t_scale        <= 16'd16;
            r_cfg.phi_scale      <= 16'd16;
            r_cfg.phi_edge_width <= 17'd4096;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_LAYER:     r_cfg.layer_select   <= pwdata[5:0];
                REG_PHI_COLS:  r_cfg.phi_columns    <= pwdata[6:0];
                REG_T_ROWS:    r_cfg.t_rows         <= pwdata[5:0];
                REG_T_MIN:     r_cfg.t_min          <= pwdata[15:0];
                REG_T_SCALE:   r_cfg.t_scale        <= pwdata[15:0];
                REG_PHI_SCALE: r_cfg.phi_scale      <= pwdata[15:0];
                REG_PHI_EDGE:  r_cfg.phi_edge_width <= pwdata[16:0];
                default:       r_cfg.layer_select   <= r_cfg.layer_select;
            endcase
        end
    end

    // read back configuration registers
    always_comb begin
        case (reg_idx)
            REG_LAYER:     prdata = {26'd0, r_cfg.layer_select};
            REG_PHI_COLS:  prdata = {25'd0, r_cfg.phi_columns};
            REG_T_ROWS:    prdata = {26'd0, r_cfg.t_rows};
            REG_T_MIN:     prdata = {16'd0, r_cfg.t_min};
            REG_T_SCALE:   prdata = {16'd0, r_cfg.t_scale};
            REG_PHI_SCALE: prdata = {16'd0, r_cfg.phi_scale};
            REG_PHI_EDGE:  prdata = {15'd0, r_cfg.phi_edge_width};
            default:       prdata = 32'd0;
        endcase
    end

    hgbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    hgbs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (cmd),
        .i_hit_id          (i_hit_id),
        .i_hit_layer       (i_hit_layer),
        .i_hit_used        (i_hit_used),
        .i_phi             (i_phi),
        .i_t_coord         (i_t_coord),
        .i_address         (i_address),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_accepted        (o_accepted),
        .o_bin_first       (o_bin_first),
        .o_bin_count       (o_bin_count),
        .o_slot_hit_id     (o_slot_hit_id),
        .o_slot_search_phi (o_slot_search_phi),
        .o_slot_is_clone   (o_slot_is_clone),
        .o_total_stored    (o_total_stored)
    );

endmodule
`default_nettype wire

@@ rtl/hgbs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hgbs_ctrl import hgbs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [2:0] i_kind,
    input  wire t_sts       i_sts,
    output logic            busy,
    output t_cmd            o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INS_MUL = 5'd1;
    localparam logic [4:0] S_INS_ROW = 5'd2;
    localparam logic [4:0] S_INS_CHK = 5'd3;
    localparam logic [4:0] S_INS_WR1 = 5'd4;
    localparam logic [4:0] S_ZERO    = 5'd5;
    localparam logic [4:0] S_CNT_A   = 5'd6;
    localparam logic [4:0] S_CNT_B   = 5'd7;
    localparam logic [4:0] S_CNT_C   = 5'd8;
    localparam logic [4:0] S_PRE_A   = 5'd9;
    localparam logic [4:0] S_PRE_B   = 5'd10;
    localparam logic [4:0] S_SCT_A   = 5'd11;
    localparam logic [4:0] S_SCT_B   = 5'd12;
    localparam logic [4:0] S_SCT_C   = 5'd13;
    localparam logic [4:0] S_FIN_END = 5'd14;
    localparam logic [4:0] S_RD_CHK  = 5'd15;
    localparam logic [4:0] S_CLEAR   = 5'd16;
    localparam logic [4:0] S_EMIT    = 5'd17;

    logic [4:0] r_state, n_state;
    logic [2:0] r_kind, n_kind;
    logic [1:0] r_res, n_res;
    logic [1:0] r_stat, n_stat;

    // hold state and pending result format
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_INSERT;
            r_res   <= RES_PLAIN;
            r_stat  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_res   <= n_res;
            r_stat  <= n_stat;
        end
    end

    assign busy = (r_state != S_IDLE);

    // sequence each request
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_res        = r_res;
        n_stat       = r_stat;
        o_cmd.op     = OP_NONE;
        o_cmd.emit   = 1'b0;
        o_cmd.res    = r_res;
        o_cmd.status = r_stat;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_kind   = i_kind;
                    n_res    = RES_PLAIN;
                    n_stat   = ST_OK;
                    case (i_kind)
                        KIND_INSERT:    n_state = S_INS_MUL;
                        KIND_FINALIZE:  n_state = S_ZERO;
                        KIND_READ_BIN:  n_state = S_RD_CHK;
                        KIND_READ_SLOT: n_state = S_RD_CHK;
                        KIND_CLEAR:     n_state = S_CLEAR;
                        default:        n_state = S_EMIT;
                    endcase
                end
            end
            S_INS_MUL: begin
                o_cmd.op = OP_INS_MUL;
                n_state  = S_INS_ROW;
            end
            S_INS_ROW: begin
                o_cmd.op = OP_INS_ROW;
                n_state  = S_INS_CHK;
            end
            S_INS_CHK: begin
                n_state = S_EMIT;
                if (i_sts.ignore) begin
                    n_stat = ST_OK;
                end else if (i_sts.range_err) begin
                    n_stat = ST_RANGE;
                end else if (i_sts.full) begin
                    n_stat = ST_FULL;
                end else begin
                    o_cmd.op = OP_INS_WR0;
                    n_res    = RES_INS;
                    if (i_sts.need2) n_state = S_INS_WR1;
                end
            end
            S_INS_WR1: begin
                o_cmd.op = OP_INS_WR1;
                n_state  = S_EMIT;
            end
            S_ZERO: begin
                if (i_sts.idx_at_nb) begin
                    o_cmd.op = OP_IDX_RST;
                    n_state  = S_CNT_A;
                end else begin
                    o_cmd.op = OP_ZERO;
                end
            end
            S_CNT_A: begin
                if (i_sts.idx_at_total) begin
                    o_cmd.op = OP_IDX_RST;
                    n_state  = S_PRE_A;
                end else begin
                    n_state = S_CNT_B;
                end
            end
            S_CNT_B: begin
                if (i_sts.bin_ok) begin
                    o_cmd.op = OP_CNT_LOOK;
                    n_state  = S_CNT_C;
                end else begin
                    o_cmd.op = OP_IDX_NEXT;
                    n_state  = S_CNT_A;
                end
            end
            S_CNT_C: begin
                o_cmd.op = OP_CNT_INC;
                n_state  = S_CNT_A;
            end
            S_PRE_A: begin
                if (i_sts.idx_at_nb) begin
                    o_cmd.op = OP_IDX_RST;
                    n_state  = S_SCT_A;
                end else begin
                    o_cmd.op = OP_PRE_RD;
                    n_state  = S_PRE_B;
                end
            end
            S_PRE_B: begin
                o_cmd.op = OP_PRE_WR;
                n_state  = S_PRE_A;
            end
            S_SCT_A: begin
                if (i_sts.idx_at_total) begin
                    n_state = S_FIN_END;
                end else begin
                    n_state = S_SCT_B;
                end
            end
            S_SCT_B: begin
                if (i_sts.bin_ok) begin
                    o_cmd.op = OP_SCT_LOOK;
                    n_state  = S_SCT_C;
                end else begin
                    o_cmd.op = OP_IDX_NEXT;
                    n_state  = S_SCT_A;
                end
            end
            S_SCT_C: begin
                o_cmd.op = OP_SCT_WR;
                n_state  = S_SCT_A;
            end
            S_FIN_END: begin
                o_cmd.op = OP_FIN_DONE;
                n_state  = S_EMIT;
            end
            S_RD_CHK: begin
                n_state = S_EMIT;
                if (!i_sts.ready) begin
                    n_stat = ST_NFIN;
                end else if (r_kind == KIND_READ_BIN) begin
                    if (i_sts.addr_bin_oob) begin
                        n_stat = ST_RANGE;
                    end else begin
                        o_cmd.op = OP_RD_ISSUE;
                        n_res    = RES_BIN;
                    end
                end else begin
                    if (i_sts.addr_slot_oob) begin
                        n_stat = ST_RANGE;
                    end else begin
                        o_cmd.op = OP_RD_ISSUE;
                        n_res    = RES_SLOT;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/hgbs_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hgbs_dp import hgbs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_cmd               i_cmd,
    input  wire logic [19:0]        i_hit_id,
    input  wire logic [5:0]         i_hit_layer,
    input  wire logic               i_hit_used,
    input  wire logic signed [15:0] i_phi,
    input  wire logic signed [15:0] i_t_coord,
    input  wire logic [12:0]        i_address,
    output t_sts                    o_sts,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [1:0]              o_accepted,
    output logic [13:0]             o_bin_first,
    output logic [13:0]             o_bin_count,
    output logic [19:0]             o_slot_hit_id,
    output logic signed [17:0]      o_slot_search_phi,
    output logic                    o_slot_is_clone,
    output logic [13:0]             o_total_stored
);

    localparam int PEND_W = BIN_AW + 20 + 18;
    localparam int SORT_W = 20 + 18 + 1;

    // latched request
    logic [19:0] r_hit;
    logic [5:0]  r_layer;
    logic        r_used;
    logic [15:0] r_phi;
    logic [15:0] r_t;
    logic [12:0] r_addr;

    // insert pipeline
    logic [31:0]       r_pphi, r_pt;
    logic              r_dtneg, r_range, r_hi, r_need2;
    logic [6:0]        r_iphi;
    logic [14:0]       r_row;

    // store bookkeeping
    logic [CNT_W-1:0] r_total, r_idx, r_sum, r_stored;
    logic             r_ready;

    // memories
    logic [PEND_W-1:0] m_pend [MAX_ENTRIES];
    logic [PEND_W-1:0] r_pend_q;
    logic [CNT_W-1:0]  m_cnt [MAX_BINS];
    logic [CNT_W-1:0]  r_cnt_q;
    logic [CNT_W-1:0]  m_first [MAX_BINS];
    logic [CNT_W-1:0]  r_first_q;
    logic [SORT_W-1:0] m_sort [MAX_ENTRIES];
    logic [SORT_W-1:0] r_sort_q;

    logic [6:0]         cols;
    logic [5:0]         rows;
    logic [7:0]         w;
    logic [6:0]         h;
    logic [14:0]        nb_full;
    logic [CNT_W-1:0]   nb;
    logic [15:0]        u_phi;
    logic [16:0]        dt;
    logic [15:0]        iphi, it;
    logic [6:0]         it_p1;
    logic [14:0]        row_full;
    logic signed [18:0] phi19, hi_lim, lo_lim;
    logic               hi_zone, lo_zone;
    logic [15:0]        b0_full, b1_full;
    logic               bin_oob;
    logic [BIN_AW-1:0]  b0, b1;
    logic [17:0]        sphi0, sphi1;
    logic [CNT_W:0]     need_sum;
    logic [BIN_AW-1:0]  pb;
    logic [19:0]        ph;
    logic [17:0]        pp;
    logic               p_clone;
    logic [BIN_AW-1:0]  tab_ra;
    logic               cnt_we;
    logic [BIN_AW-1:0]  cnt_wa;
    logic [CNT_W-1:0]   cnt_wd;
    logic [ENT_AW-1:0]  slot;

    // grid geometry
    assign cols    = (i_cfg.phi_columns == 7'd0) ? 7'd1 : i_cfg.phi_columns;
    assign rows    = (i_cfg.t_rows == 6'd0) ? 6'd1 : i_cfg.t_rows;
    assign w       = {1'b0, cols} + 8'd2;
    assign h       = {1'b0, rows} + 7'd2;
    assign nb_full = 15'(w) * 15'(h);
    assign nb      = (nb_full > 15'(MAX_BINS)) ? CNT_W'(MAX_BINS) : nb_full[CNT_W-1:0];

    // insert arithmetic
    assign u_phi    = {~r_phi[15], r_phi[14:0]};
    assign dt       = {r_t[15], r_t} - {i_cfg.t_min[15], i_cfg.t_min};
    assign iphi     = r_pphi[31:16];
    assign it       = r_pt[31:16];
    assign it_p1    = {1'b0, it[5:0]} + 7'd1;
    assign row_full = 15'(it_p1) * 15'(w);
    assign phi19    = {{3{r_phi[15]}}, r_phi};
    assign hi_lim   = 19'sd32768 - $signed({2'b00, i_cfg.phi_edge_width});
    assign lo_lim   = -19'sd32768 + $signed({2'b00, i_cfg.phi_edge_width});
    assign hi_zone  = phi19 > hi_lim;
    assign lo_zone  = phi19 < lo_lim;
    // full-width bin indexes, checked against the bin store size
    assign b0_full  = {1'b0, r_row} + 16'(r_iphi) + 16'd1;
    assign b1_full  = r_hi ? {1'b0, r_row} : ({1'b0, r_row} + 16'(w) - 16'd1);
    assign bin_oob  = (b0_full >= 16'(MAX_BINS)) || (r_need2 && (b1_full >= 16'(MAX_BINS)));
    assign b0       = b0_full[BIN_AW-1:0];
    assign b1       = b1_full[BIN_AW-1:0];
    assign sphi0    = {{2{r_phi[15]}}, r_phi};
    assign sphi1    = r_hi ? (sphi0 - 18'h10000) : (sphi0 + 18'h10000);
    assign need_sum = {1'b0, r_total} + (r_need2 ? (CNT_W+1)'(2) : (CNT_W+1)'(1));

    // fields of the pending entry under the walk
    assign pb      = r_pend_q[PEND_W-1 -: BIN_AW];
    assign ph      = r_pend_q[37:18];
    assign pp      = r_pend_q[17:0];
    assign p_clone = !((pp[17:15] == 3'b000) || (pp[17:15] == 3'b111));
    assign slot    = r_first_q[ENT_AW-1:0] + r_cnt_q[ENT_AW-1:0];

    // status to the controller
    assign o_sts.ignore        = (r_layer != i_cfg.layer_select) || r_used;
    assign o_sts.range_err     = r_range || bin_oob;
    assign o_sts.full          = need_sum > (CNT_W+1)'(MAX_ENTRIES);
    assign o_sts.need2         = r_need2;
    assign o_sts.ready         = r_ready;
    assign o_sts.idx_at_nb     = (r_idx == nb);
    assign o_sts.idx_at_total  = (r_idx == r_total);
    assign o_sts.bin_ok        = {1'b0, pb} < nb;
    assign o_sts.addr_bin_oob  = {1'b0, r_addr} >= nb;
    assign o_sts.addr_slot_oob = {1'b0, r_addr} >= r_stored;

    // bin table read address and count write port
    always_comb begin
        case (i_cmd.op)
            OP_CNT_LOOK, OP_SCT_LOOK: tab_ra = pb;
            OP_RD_ISSUE:              tab_ra = r_addr;
            default:                  tab_ra = r_idx[BIN_AW-1:0];
        endcase
        cnt_we = 1'b0;
        cnt_wa = r_idx[BIN_AW-1:0];
        cnt_wd = '0;
        case (i_cmd.op)
            OP_ZERO, OP_PRE_WR: cnt_we = 1'b1;
            OP_CNT_INC, OP_SCT_WR: begin
                cnt_we = 1'b1;
                cnt_wa = pb;
                cnt_wd = r_cnt_q + CNT_W'(1);
            end
            default: cnt_we = 1'b0;
        endcase
    end

    // latch request fields and run the insert pipeline
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_hit   <= i_hit_id;
                r_layer <= i_hit_layer;
                r_used  <= i_hit_used;
                r_phi   <= i_phi;
                r_t     <= i_t_coord;
                r_addr  <= i_address;
            end
            OP_INS_MUL: begin
                r_pphi  <= u_phi * i_cfg.phi_scale;
                r_pt    <= dt[15:0] * i_cfg.t_scale;
                r_dtneg <= dt[16];
            end
            OP_INS_ROW: begin
                r_range <= r_dtneg || (iphi >= {9'd0, cols}) || (it >= {10'd0, rows});
                r_iphi  <= iphi[6:0];
                r_row   <= row_full;
                r_hi    <= hi_zone;
                r_need2 <= hi_zone || lo_zone;
            end
            default: r_range <= r_range;
        endcase
    end

    // advance counters and store state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_stored <= '0;
            r_ready  <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD, OP_IDX_RST: begin
                    r_idx <= '0;
                    if (i_cmd.op == OP_LOAD) r_sum <= '0;
                end
                OP_INS_WR0, OP_INS_WR1: begin
                    r_total <= r_total + CNT_W'(1);
                    r_ready <= 1'b0;
                end
                OP_ZERO, OP_IDX_NEXT, OP_CNT_INC, OP_SCT_WR: r_idx <= r_idx + CNT_W'(1);
                OP_PRE_WR: begin
                    r_idx <= r_idx + CNT_W'(1);
                    r_sum <= r_sum + r_cnt_q;
                end
                OP_FIN_DONE: begin
                    r_stored <= r_sum;
                    r_ready  <= 1'b1;
                end
                OP_CLEAR: begin
                    r_total  <= '0;
                    r_stored <= '0;
                    r_ready  <= 1'b0;
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    // pending store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_INS_WR0) begin
            m_pend[r_total[ENT_AW-1:0]] <= {b0, r_hit, sphi0};
        end else if (i_cmd.op == OP_INS_WR1) begin
            m_pend[r_total[ENT_AW-1:0]] <= {b1, r_hit, sphi1};
        end
        r_pend_q <= m_pend[r_idx[ENT_AW-1:0]];
    end

    // per-bin count table
    always_ff @(posedge i_clk) begin
        if (cnt_we) m_cnt[cnt_wa] <= cnt_wd;
        r_cnt_q <= m_cnt[tab_ra];
    end

    // per-bin first-slot table
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PRE_WR) m_first[r_idx[BIN_AW-1:0]] <= r_sum;
        r_first_q <= m_first[tab_ra];
    end

    // sorted slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SCT_WR) m_sort[slot] <= {ph, pp, p_clone};
        r_sort_q <= m_sort[r_addr];
    end

    // drive one result per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_status          <= i_cmd.status;
            o_accepted        <= 2'd0;
            o_bin_first       <= '0;
            o_bin_count       <= '0;
            o_slot_hit_id     <= '0;
            o_slot_search_phi <= '0;
            o_slot_is_clone   <= 1'b0;
            o_total_stored    <= r_ready ? r_stored : '0;
            case (i_cmd.res)
                RES_INS: o_accepted <= r_need2 ? 2'd2 : 2'd1;
                RES_BIN: begin
                    o_bin_first <= r_first_q;
                    o_bin_count <= r_cnt_q;
                end
                RES_SLOT: begin
                    o_slot_hit_id     <= r_sort_q[38:19];
                    o_slot_search_phi <= r_sort_q[18:1];
                    o_slot_is_clone   <= r_sort_q[0];
                end
                default: o_accepted <= 2'd0;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/hgbs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "hit_grid_binning_sorter_defines.svh"
module hgbs_props import hgbs_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [1:0]  o_status,
    input wire logic [1:0]  o_accepted,
    input wire logic [13:0] o_bin_first,
    input wire logic [13:0] o_bin_count
);

    // an accepted request keeps the block busy
    `HGBS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
    // no result strobe directly follows another
    `HGBS_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than a cycle")
    // a result always closes a busy period
    `HGBS_ASSERT_NOW(a_result_after_busy, o_valid, $past(busy), "result without busy period")
    // stored entries only come with an ok status and no bin fields
    `HGBS_ASSERT_NOW(a_accept_ok, o_valid && (o_accepted != 2'd0),
        (o_status == ST_OK) && (o_bin_first == 14'd0) && (o_bin_count == 14'd0),
        "insert result with stray fields")

endmodule

bind hit_grid_binning_sorter hgbs_props u_hgbs_props (.*);
`default_nettype wire
